FILE: sv/assert_macros.svh
// Assertion macros used by the free list RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clk edge outside reset.
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Check a property on every rising clk edge, reset included.
`define ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

FILE: sv/dpfl_pkg.sv
// Package with sizes, codes and payload types of the dual pool free list.
package dpfl_pkg;

  localparam int MAIN_DEPTH     = 256;
  localparam int RESERVED_DEPTH = 16;
  localparam int ADDR_WIDTH     = 48;

  localparam int MAIN_AW = (MAIN_DEPTH > 1) ? $clog2(MAIN_DEPTH) : 1;
  localparam int RES_AW  = (RESERVED_DEPTH > 1) ? $clog2(RESERVED_DEPTH) : 1;
  localparam int MAIN_CW = $clog2(MAIN_DEPTH + 1);
  localparam int RES_CW  = $clog2(RESERVED_DEPTH + 1);

  localparam logic [1:0] KIND_ALLOC_MAIN = 2'd0;
  localparam logic [1:0] KIND_ALLOC_RES  = 2'd1;
  localparam logic [1:0] KIND_FREE       = 2'd2;
  localparam logic [1:0] KIND_UNUSED     = 2'd3;

  localparam logic [1:0] STATUS_OK    = 2'd0;
  localparam logic [1:0] STATUS_EMPTY = 2'd1;
  localparam logic [1:0] STATUS_FULL  = 2'd2;

  // Which pool delivers the granted address.
  localparam logic [1:0] SRC_NONE = 2'd0;
  localparam logic [1:0] SRC_MAIN = 2'd1;
  localparam logic [1:0] SRC_RES  = 2'd2;

  typedef struct packed {
    logic [1:0]            kind;
    logic [ADDR_WIDTH-1:0] buffer_address;
  } req_t;

  typedef struct packed {
    logic [ADDR_WIDTH-1:0] granted_address;
    logic [1:0]            status;
  } rsp_t;

  typedef struct packed {
    logic               we;
    logic [MAIN_AW-1:0] waddr;
    logic               re;
    logic [MAIN_AW-1:0] raddr;
  } main_port_t;

  typedef struct packed {
    logic              we;
    logic [RES_AW-1:0] waddr;
    logic              re;
    logic [RES_AW-1:0] raddr;
  } res_port_t;

endpackage

FILE: sv/dpfl_ram.sv
// Generic single write, single read RAM with registered read data.
module dpfl_ram #(
  parameter int DEPTH = 16,
  parameter int WIDTH = 8,
  parameter int AW    = 4
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: sv/dpfl_alloc.sv
// Stack pointer control: decode a request, update the pool counts, drive the stores.
`include "assert_macros.svh"

module dpfl_alloc (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           req_valid,
  input  dpfl_pkg::req_t                 req,
  input  logic [dpfl_pkg::ADDR_WIDTH-1:0] reserved_base,
  output dpfl_pkg::main_port_t           main_port,
  output dpfl_pkg::res_port_t            res_port,
  output logic                           rsp_valid,
  output logic [1:0]                     rsp_status,
  output logic [1:0]                     rsp_src
);
  import dpfl_pkg::*;

  logic [MAIN_CW-1:0] main_count, main_count_next, main_dec;
  logic [RES_CW-1:0]  res_count, res_count_next, res_dec;
  logic [1:0]         status_next, src_next;
  logic               main_full, res_full;

  assign main_dec  = main_count - MAIN_CW'(1);
  assign res_dec   = res_count - RES_CW'(1);
  assign main_full = (main_count == MAIN_CW'(MAIN_DEPTH));
  assign res_full  = (res_count == RES_CW'(RESERVED_DEPTH));

  always_comb begin
    main_count_next = main_count;
    res_count_next  = res_count;
    status_next     = STATUS_OK;
    src_next        = SRC_NONE;
    main_port.we    = 1'b0;
    main_port.waddr = main_count[MAIN_AW-1:0];
    main_port.re    = 1'b0;
    main_port.raddr = main_dec[MAIN_AW-1:0];
    res_port.we     = 1'b0;
    res_port.waddr  = res_count[RES_AW-1:0];
    res_port.re     = 1'b0;
    res_port.raddr  = res_dec[RES_AW-1:0];
    if (req_valid) begin
      unique case (req.kind)
        KIND_ALLOC_MAIN: begin
          if (main_count == '0) begin
            status_next = STATUS_EMPTY;
          end else begin
            main_port.re    = 1'b1;
            main_count_next = main_dec;
            src_next        = SRC_MAIN;
          end
        end
        KIND_ALLOC_RES: begin
          if (res_count == '0) begin
            status_next = STATUS_EMPTY;
          end else begin
            res_port.re    = 1'b1;
            res_count_next = res_dec;
            src_next       = SRC_RES;
          end
        end
        KIND_FREE: begin
          // Route the address to the reserved pool at or above the base.
          if (req.buffer_address >= reserved_base) begin
            if (res_full) begin
              status_next = STATUS_FULL;
            end else begin
              res_port.we    = 1'b1;
              res_count_next = res_count + RES_CW'(1);
            end
          end else begin
            if (main_full) begin
              status_next = STATUS_FULL;
            end else begin
              main_port.we    = 1'b1;
              main_count_next = main_count + MAIN_CW'(1);
            end
          end
        end
        KIND_UNUSED: begin
          status_next = STATUS_OK;
        end
        default: begin
          status_next = STATUS_OK;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      main_count <= '0;
      res_count  <= '0;
      rsp_valid  <= 1'b0;
      rsp_src    <= SRC_NONE;
    end else begin
      main_count <= main_count_next;
      res_count  <= res_count_next;
      rsp_valid  <= req_valid;
      rsp_src    <= src_next;
    end
  end

  always_ff @(posedge clk) begin
    rsp_status <= status_next;
  end

  `ASSERT_CLK(a_main_bound, main_count <= MAIN_CW'(MAIN_DEPTH), "main pool count overflow")
  `ASSERT_CLK(a_res_bound, res_count <= RES_CW'(RESERVED_DEPTH), "reserved pool count overflow")
  `ASSERT_CLK(a_one_rsp, req_valid |=> rsp_valid, "request without response")
  `ASSERT_CLK(a_idle_hold, !req_valid |=> $stable(main_count) && $stable(res_count), "count moved while idle")
  `ASSERT_CLK(a_grant_ok, rsp_src != SRC_NONE |-> rsp_status == STATUS_OK, "grant with bad status")

endmodule

FILE: sv/dual_pool_buffer_free_list_core.sv
// Top level of the dual pool LIFO buffer free list.
// Usage:
//   Request channel: drive req and pulse start; a request is taken at each edge where
//   start is high and busy is low. busy is only high during reset, so one request may
//   be issued every cycle.
//   Kinds: allocate from the main pool, allocate from the reserved pool, or free an
//   address; a free goes to the reserved pool when the address is at or above
//   reserved_base, else to the main pool.
//   Result channel: done pulses for one cycle with result; a request passes the request
//   register and then the pool stage, whose stores have registered read ports. Results
//   come out in request order, one per request.
//   Throughput is one request per cycle, set by the single pool update stage.
//   The receiver cannot stall: result is valid only in the cycle done is high.
//   Configuration: write reserved_base with cfg_valid/cfg_ready while no request is
//   in flight; cfg_ready is high outside reset.
//   Reset: synchronous rst empties both pools and clears reserved_base; store contents
//   are not cleared, and no clearing pass is needed.
module dual_pool_buffer_free_list_core (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            start,
  output logic                            busy,
  input  dpfl_pkg::req_t                  req,
  output logic                            done,
  output dpfl_pkg::rsp_t                  result,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [dpfl_pkg::ADDR_WIDTH-1:0] cfg_data
);
  import dpfl_pkg::*;

  logic                  req_valid;
  req_t                  req_q;
  logic [ADDR_WIDTH-1:0] reserved_base;
  main_port_t            main_port;
  res_port_t             res_port;
  logic                  rsp_valid;
  logic [1:0]            rsp_status;
  logic [1:0]            rsp_src;
  logic [ADDR_WIDTH-1:0] main_rdata, res_rdata;

  assign busy      = rst;
  assign cfg_ready = !rst;

  always_ff @(posedge clk) begin
    if (rst) begin
      req_valid     <= 1'b0;
      reserved_base <= '0;
    end else begin
      req_valid <= start && !busy;
      if (cfg_valid && cfg_ready) begin
        reserved_base <= cfg_data;
      end
    end
  end

  // Hold the request payload for the pool stage.
  always_ff @(posedge clk) begin
    if (start && !busy) begin
      req_q <= req;
    end
  end

  dpfl_alloc u_alloc (
    .clk           (clk),
    .rst           (rst),
    .req_valid     (req_valid),
    .req           (req_q),
    .reserved_base (reserved_base),
    .main_port     (main_port),
    .res_port      (res_port),
    .rsp_valid     (rsp_valid),
    .rsp_status    (rsp_status),
    .rsp_src       (rsp_src)
  );

  dpfl_ram #(
    .DEPTH (MAIN_DEPTH),
    .WIDTH (ADDR_WIDTH),
    .AW    (MAIN_AW)
  ) u_main_ram (
    .clk   (clk),
    .we    (main_port.we),
    .waddr (main_port.waddr),
    .wdata (req_q.buffer_address),
    .re    (main_port.re),
    .raddr (main_port.raddr),
    .rdata (main_rdata)
  );

  dpfl_ram #(
    .DEPTH (RESERVED_DEPTH),
    .WIDTH (ADDR_WIDTH),
    .AW    (RES_AW)
  ) u_res_ram (
    .clk   (clk),
    .we    (res_port.we),
    .waddr (res_port.waddr),
    .wdata (req_q.buffer_address),
    .re    (res_port.re),
    .raddr (res_port.raddr),
    .rdata (res_rdata)
  );

  assign done = rsp_valid;

  always_comb begin
    result.status = rsp_status;
    unique case (rsp_src)
      SRC_MAIN: result.granted_address = main_rdata;
      SRC_RES:  result.granted_address = res_rdata;
      default:  result.granted_address = '0;
    endcase
  end

endmodule

FILE: test/tb.sv
// Self-checking bench for the dual pool buffer free list: directed table, then random traffic.
`timescale 1ns / 1ps

module tb;
  import dpfl_pkg::*;

  localparam logic [ADDR_WIDTH-1:0] ADDR_MAX = {ADDR_WIDTH{1'b1}};
  localparam int CYCLE_LIMIT = 400000;
  localparam int DRAIN_CYCLES = 8;

  typedef struct {
    bit                    is_cfg;
    logic [1:0]            kind;
    logic [ADDR_WIDTH-1:0] addr;
    int                    reps;
    bit                    fixed;
    rsp_t                  want;
  } plan_row_t;

  logic                  clk = 1'b0;
  logic                  rst;
  logic                  start;
  logic                  busy;
  req_t                  req;
  logic                  done;
  rsp_t                  result;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [ADDR_WIDTH-1:0] cfg_data;

  // Pool model state
  logic [ADDR_WIDTH-1:0] main_stack [MAIN_DEPTH];
  logic [ADDR_WIDTH-1:0] res_stack [RESERVED_DEPTH];
  int                    main_fill = 0;
  int                    res_fill = 0;
  logic [ADDR_WIDTH-1:0] split_base = '0;

  rsp_t responses_due [$];
  bit   row_fixed;
  rsp_t row_want;
  int   idle_pct;
  int   mismatches = 0;
  int   cycle_count = 0;

  dual_pool_buffer_free_list_core DUT (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .req       (req),
    .done      (done),
    .result    (result),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Pop or push one request against the model pools and return its response.
  function automatic rsp_t pool_response(req_t r);
    rsp_t o;
    o.granted_address = '0;
    o.status = STATUS_OK;
    case (r.kind)
      KIND_ALLOC_MAIN: begin
        if (main_fill == 0) o.status = STATUS_EMPTY;
        else begin
          main_fill--;
          o.granted_address = main_stack[main_fill];
        end
      end
      KIND_ALLOC_RES: begin
        if (res_fill == 0) o.status = STATUS_EMPTY;
        else begin
          res_fill--;
          o.granted_address = res_stack[res_fill];
        end
      end
      KIND_FREE: begin
        if (r.buffer_address >= split_base) begin
          if (res_fill >= RESERVED_DEPTH) o.status = STATUS_FULL;
          else begin
            res_stack[res_fill] = r.buffer_address;
            res_fill++;
          end
        end else begin
          if (main_fill >= MAIN_DEPTH) o.status = STATUS_FULL;
          else begin
            main_stack[main_fill] = r.buffer_address;
            main_fill++;
          end
        end
      end
      default: ;
    endcase
    return o;
  endfunction

  // Pick a free address below, at or above the split, edges included.
  function automatic logic [ADDR_WIDTH-1:0] pick_address(logic [ADDR_WIDTH-1:0] b);
    logic [63:0]           r;
    logic [63:0]           span;
    logic [ADDR_WIDTH-1:0] a;
    r = {$urandom, $urandom};
    case ($urandom_range(9))
      0: a = '0;
      1: a = ADDR_MAX;
      2: a = b;
      3: a = b - 1'b1;
      4, 5, 6: begin
        if (b != '0) a = ADDR_WIDTH'(r % 64'(b));
        else a = r[ADDR_WIDTH-1:0];
      end
      default: begin
        span = 64'(ADDR_MAX) - 64'(b) + 64'd1;
        a = ADDR_WIDTH'(64'(b) + r % span);
      end
    endcase
    return a;
  endfunction

  function automatic plan_row_t mk_row(bit c, logic [1:0] k, logic [ADDR_WIDTH-1:0] a,
                                       int n, bit fx, logic [ADDR_WIDTH-1:0] ga,
                                       logic [1:0] st);
    plan_row_t p;
    p.is_cfg = c;
    p.kind = k;
    p.addr = a;
    p.reps = n;
    p.fixed = fx;
    p.want.granted_address = ga;
    p.want.status = st;
    return p;
  endfunction

  // Score responses, then record the request taken at this edge.
  always @(posedge clk) begin
    rsp_t want;
    rsp_t got;
    if (!rst) begin
      if (done === 1'b1) begin
        if (responses_due.size() == 0) begin
          if (mismatches < 10)
            $display("unexpected response: addr %h status %0d",
                     result.granted_address, result.status);
          mismatches++;
        end else begin
          want = responses_due.pop_front();
          if (result.granted_address !== want.granted_address ||
              result.status !== want.status) begin
            if (mismatches < 10)
              $display("mismatch: addr exp %h got %h, status exp %0d got %0d",
                       want.granted_address, result.granted_address,
                       want.status, result.status);
            mismatches++;
          end
        end
      end
      if (start === 1'b1 && busy === 1'b0) begin
        got = pool_response(req);
        responses_due.push_back(row_fixed ? row_want : got);
      end
      if (cfg_valid === 1'b1 && cfg_ready === 1'b1) split_base = cfg_data;
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // Entered and left at a falling edge; start stays high for back-to-back requests.
  task automatic issue(input req_t r, input bit fx, input rsp_t w);
    while ($urandom_range(99) < idle_pct) begin
      start = 1'b0;
      @(negedge clk);
    end
    req = r;
    row_fixed = fx;
    row_want = w;
    start = 1'b1;
    do @(posedge clk); while (busy !== 1'b0);
    @(negedge clk);
  endtask

  // Hold requests until every response is back, then let the pipe empty.
  task automatic settle();
    start = 1'b0;
    while (responses_due.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic write_base(input logic [ADDR_WIDTH-1:0] v);
    cfg_data = v;
    cfg_valid = 1'b1;
    do @(posedge clk); while (cfg_ready !== 1'b1);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  initial begin
    plan_row_t             plan [$];
    req_t                  r;
    rsp_t                  none;
    logic [ADDR_WIDTH-1:0] b;
    int                    free_pct;
    int                    n_items;
    int                    roll;
    start = 1'b0;
    req = '0;
    cfg_valid = 1'b0;
    cfg_data = '0;
    row_fixed = 1'b0;
    row_want = '0;
    none = '0;
    idle_pct = 37;
    rst = 1'b1;

    // Split at zero after reset: every free lands in the reserved pool.
    plan.push_back(mk_row(0, KIND_ALLOC_MAIN, '0, 1, 1, '0, STATUS_EMPTY));
    plan.push_back(mk_row(0, KIND_ALLOC_RES, '0, 1, 1, '0, STATUS_EMPTY));
    plan.push_back(mk_row(0, KIND_UNUSED, ADDR_MAX, 1, 1, '0, STATUS_OK));
    plan.push_back(mk_row(0, KIND_FREE, ADDR_MAX, 1, 1, '0, STATUS_OK));
    plan.push_back(mk_row(0, KIND_ALLOC_RES, '0, 1, 1, ADDR_MAX, STATUS_OK));
    // Split at the top: only the all-ones address is reserved.
    plan.push_back(mk_row(1, '0, ADDR_MAX, 1, 0, '0, STATUS_OK));
    plan.push_back(mk_row(0, KIND_FREE, ADDR_MAX - 1'b1, 1, 1, '0, STATUS_OK));
    plan.push_back(mk_row(0, KIND_FREE, ADDR_MAX, 1, 1, '0, STATUS_OK));
    plan.push_back(mk_row(0, KIND_ALLOC_MAIN, '0, 1, 1, ADDR_MAX - 1'b1, STATUS_OK));
    plan.push_back(mk_row(0, KIND_ALLOC_RES, ADDR_MAX, 1, 1, ADDR_MAX, STATUS_OK));
    // Fill the reserved pool, then overflow it.
    plan.push_back(mk_row(1, '0, '0, 1, 0, '0, STATUS_OK));
    plan.push_back(mk_row(0, KIND_FREE, 48'h5555_5555_5550, RESERVED_DEPTH, 0, '0,
                          STATUS_OK));
    plan.push_back(mk_row(0, KIND_FREE, 48'hAAAA_AAAA_AAAA, 1, 1, '0, STATUS_FULL));
    plan.push_back(mk_row(0, KIND_ALLOC_RES, '0, 1, 0, '0, STATUS_OK));

    repeat (8) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    foreach (plan[i]) begin
      if (plan[i].is_cfg) begin
        settle();
        write_base(plan[i].addr);
      end else begin
        for (int j = 0; j < plan[i].reps; j++) begin
          r.kind = plan[i].kind;
          r.buffer_address = plan[i].addr + ADDR_WIDTH'(j);
          issue(r, plan[i].fixed, plan[i].want);
        end
      end
    end

    for (int p = 0; p < 6; p++) begin
      settle();
      idle_pct = 37;
      n_items = 320;
      b = ADDR_WIDTH'({$urandom, $urandom});
      case (p)
        0: begin
          b = ADDR_MAX;
          free_pct = 85;
          n_items = 400;
        end
        1: begin
          b = '0;
          free_pct = 50;
        end
        2: begin
          free_pct = 60;
          idle_pct = 0;
        end
        3: free_pct = 25;
        4: free_pct = 55;
        default: begin
          b = 48'd1;
          free_pct = 40;
        end
      endcase
      write_base(b);
      for (int n = 0; n < n_items; n++) begin
        if (p == 3 && n == n_items / 2) settle();
        roll = $urandom_range(99);
        r.buffer_address = ADDR_WIDTH'({$urandom, $urandom});
        if (roll < 3) r.kind = KIND_UNUSED;
        else if (roll < 3 + free_pct) begin
          r.kind = KIND_FREE;
          r.buffer_address = pick_address(b);
        end else if ($urandom_range(1) == 0) r.kind = KIND_ALLOC_MAIN;
        else r.kind = KIND_ALLOC_RES;
        issue(r, 1'b0, none);
      end
    end

    settle();
    if (mismatches == 0) $display("Regression PASS");
    else $display("Regression FAIL");
    $finish;
  end

endmodule

FILE: files.f
+incdir+sv
sv/dpfl_pkg.sv
sv/dpfl_ram.sv
sv/dpfl_alloc.sv
sv/dual_pool_buffer_free_list_core.sv
test/tb.sv
